### rtl/half_step_stepper_key_controller_macros.svh
// Assertion helpers; clocked on clk_i and disabled while rst_ni is low.
`ifndef HALF_STEP_STEPPER_KEY_CONTROLLER_MACROS_SVH
`define HALF_STEP_STEPPER_KEY_CONTROLLER_MACROS_SVH

`ifndef SYNTH
`define HSSK_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
`define HSSK_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define HSSK_ASSERT_IMP(lbl, ante, cons)
`define HSSK_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

### rtl/hssk_pkg.sv
`default_nettype none

package hssk_pkg;

  localparam int PHASE_COUNT = 8;
  localparam int PHASE_W     = $clog2(PHASE_COUNT);
  localparam int KEY_W       = 4;
  localparam int COIL_W      = 4;
  localparam int DIV_W       = 8;
  localparam int JOG_W       = 8;

  typedef logic [PHASE_W-1:0] phase_t;

  localparam phase_t PHASE_FIRST = '0;
  localparam phase_t PHASE_LAST  = phase_t'(PHASE_COUNT - 1);

  // Key indices, automatic mode
  localparam int KEY_DIR = 0;
  localparam int KEY_DEC = 1;
  localparam int KEY_INC = 2;
  localparam int KEY_MAN = 3;
  // Key indices, manual mode
  localparam int KEY_JOG_FWD = 0;
  localparam int KEY_JOG_BWD = 1;
  localparam int KEY_AUTO    = 2;

  localparam logic [KEY_W-1:0] KEYS_RELEASED = '1;
  localparam logic [DIV_W-1:0] DIV_MAX       = '1;
  localparam logic [JOG_W-1:0] JOG_RESET     = JOG_W'(1);

  typedef struct packed {
    logic [COIL_W-1:0] coil_pattern;
    logic              reverse_dir;
    logic              in_manual;
    logic [DIV_W-1:0]  speed_divider;
  } hssk_result_t;

  // Half-step coil sequence
  function automatic logic [COIL_W-1:0] coil_of(input phase_t phase);
    logic [COIL_W-1:0] pat;
    case (phase)
      3'd0:    pat = 4'h1;
      3'd1:    pat = 4'h3;
      3'd2:    pat = 4'h2;
      3'd3:    pat = 4'h6;
      3'd4:    pat = 4'h4;
      3'd5:    pat = 4'hC;
      3'd6:    pat = 4'h8;
      3'd7:    pat = 4'h9;
      default: pat = 4'h0;
    endcase
    return pat;
  endfunction

  function automatic phase_t phase_next(input phase_t phase, input logic rev);
    return rev ? phase_t'(phase - phase_t'(1)) : phase_t'(phase + phase_t'(1));
  endfunction

endpackage

`default_nettype wire

### rtl/hssk_core.sv
`default_nettype none
`include "half_step_stepper_key_controller_macros.svh"

module hssk_core (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        accept_i,
  input  wire logic [hssk_pkg::KEY_W-1:0]  key_levels_i,
  input  wire logic                        cfg_we_i,
  input  wire logic [hssk_pkg::JOG_W-1:0]  cfg_wdata_i,
  output hssk_pkg::hssk_result_t           result_o
);
  import hssk_pkg::*;

  phase_t             sp_q, sp_d, jp_q, jp_d;
  logic               dir_q, dir_d, man_q, man_d;
  logic [DIV_W-1:0]   div_q, div_d, tick_q, tick_d, tick_inc;
  logic [KEY_W-1:0]   prev_q, prev_d, pressed;
  logic [JOG_W-1:0]   jc_q, jc_d, jog_cnt, interval_m1, jog_int_q;
  logic [COIL_W-1:0]  coil_q, coil_d;
  logic               jog_fwd, jog_start;
  phase_t             jog_base;

  always_comb begin
    sp_d     = sp_q;
    jp_d     = jp_q;
    dir_d    = dir_q;
    man_d    = man_q;
    div_d    = div_q;
    tick_d   = tick_q;
    jc_d     = jc_q;
    coil_d   = coil_q;
    prev_d   = key_levels_i;
    pressed  = prev_q & ~key_levels_i;
    tick_inc = tick_q + DIV_W'(1);

    // forward jog wins when both jog keys are held
    jog_fwd     = !key_levels_i[KEY_JOG_FWD];
    jog_start   = jog_fwd ? prev_q[KEY_JOG_FWD]
                          : (prev_q[KEY_JOG_BWD] | ~prev_q[KEY_JOG_FWD]);
    jog_base    = jog_start ? (jog_fwd ? PHASE_FIRST : PHASE_LAST) : jp_q;
    jog_cnt     = jog_start ? '0 : jc_q;
    interval_m1 = (jog_int_q == '0) ? '0 : jog_int_q - JOG_W'(1);

    if (!man_q) begin
      tick_d = tick_inc;
      if (tick_inc >= div_q) begin
        tick_d = '0;
        coil_d = coil_of(sp_q);
        sp_d   = phase_next(sp_q, dir_q);
      end
      if (pressed[KEY_DIR]) begin
        dir_d  = ~dir_q;
        coil_d = coil_of(dir_d ? PHASE_LAST : PHASE_FIRST);
        sp_d   = phase_next(dir_d ? PHASE_LAST : PHASE_FIRST, dir_d);
      end
      if (pressed[KEY_DEC] && div_d != '0) begin
        div_d = div_d - DIV_W'(1);
      end
      if (pressed[KEY_INC] && div_d != DIV_MAX) begin
        div_d = div_d + DIV_W'(1);
      end
      if (pressed[KEY_MAN]) begin
        man_d               = 1'b1;
        // jog keys count as released on the first manual tick
        prev_d[KEY_JOG_FWD] = 1'b1;
        prev_d[KEY_JOG_BWD] = 1'b1;
      end
    end else if (!key_levels_i[KEY_JOG_FWD] || !key_levels_i[KEY_JOG_BWD]) begin
      if (jog_cnt == '0) begin
        sp_d   = jog_base;
        coil_d = coil_of(jog_base);
        jp_d   = phase_next(jog_base, !jog_fwd);
        jc_d   = interval_m1;
      end else begin
        jc_d   = jog_cnt - JOG_W'(1);
      end
    end else if (!key_levels_i[KEY_AUTO]) begin
      man_d = 1'b0;
      dir_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q   <= PHASE_FIRST;
      jp_q   <= PHASE_FIRST;
      dir_q  <= 1'b0;
      man_q  <= 1'b0;
      div_q  <= '0;
      tick_q <= '0;
      jc_q   <= '0;
      coil_q <= '0;
      prev_q <= KEYS_RELEASED;
    end else if (accept_i) begin
      sp_q   <= sp_d;
      jp_q   <= jp_d;
      dir_q  <= dir_d;
      man_q  <= man_d;
      div_q  <= div_d;
      tick_q <= tick_d;
      jc_q   <= jc_d;
      coil_q <= coil_d;
      prev_q <= prev_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      jog_int_q <= JOG_RESET;
    end else if (cfg_we_i) begin
      jog_int_q <= cfg_wdata_i;
    end
  end

  assign result_o.coil_pattern  = coil_d;
  assign result_o.reverse_dir   = dir_d;
  assign result_o.in_manual     = man_d;
  assign result_o.speed_divider = div_d;

  `HSSK_ASSERT_NXT(a_hold_idle, !accept_i, $stable(sp_q) && $stable(div_q) && $stable(man_q))
  `HSSK_ASSERT_NXT(a_manual_no_tick, accept_i && man_q, $stable(tick_q))
  `HSSK_ASSERT_NXT(a_auto_fwd, accept_i && man_q && !man_d, !dir_q && !man_q)
  // off, one coil, or two neighbouring coils
  `HSSK_ASSERT_IMP(a_coil_legal, 1'b1, $countones(coil_q) <= 2 && coil_q != 4'h5 && coil_q != 4'hA)

endmodule

`default_nettype wire

### rtl/half_step_stepper_key_controller.sv
// Half-step stepper key controller.
// A tick's result is registered and shown in the cycle after its transfer; one tick
// per cycle unless stalled; the result register frees itself as it is taken.
// Reset (async, active low): coils off, forward, automatic, divider 0, keys released,
// jog interval 1, output register empty.
`default_nettype none

module half_step_stepper_key_controller (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output      logic                        in_stall_o,
  input  wire logic [hssk_pkg::KEY_W-1:0]  key_levels_i,
  output      logic                        out_valid_o,
  input  wire logic                        out_stall_i,
  output      logic [hssk_pkg::COIL_W-1:0] coil_pattern_o,
  output      logic                        reverse_dir_o,
  output      logic                        in_manual_o,
  output      logic [hssk_pkg::DIV_W-1:0]  speed_divider_o,
  input  wire logic                        jog_interval_we_i,
  input  wire logic [hssk_pkg::JOG_W-1:0]  jog_interval_wdata_i
);
  import hssk_pkg::*;

  hssk_result_t res_d, res_q;
  logic         out_valid_q;
  logic         accept;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  hssk_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .key_levels_i (key_levels_i),
    .cfg_we_i     (jog_interval_we_i),
    .cfg_wdata_i  (jog_interval_wdata_i),
    .result_o     (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign coil_pattern_o  = res_q.coil_pattern;
  assign reverse_dir_o   = res_q.reverse_dir;
  assign in_manual_o     = res_q.in_manual;
  assign speed_divider_o = res_q.speed_divider;

endmodule

`default_nettype wire

### tb/sv/half_step_stepper_key_controller_tb.sv
`timescale 1ns / 100ps

module half_step_stepper_key_controller_tb;
  import hssk_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_OFF_CYCLES = 80;

  localparam logic [KEY_W-1:0] K_DIR  = KEY_W'(1 << KEY_DIR);
  localparam logic [KEY_W-1:0] K_DEC  = KEY_W'(1 << KEY_DEC);
  localparam logic [KEY_W-1:0] K_INC  = KEY_W'(1 << KEY_INC);
  localparam logic [KEY_W-1:0] K_MAN  = KEY_W'(1 << KEY_MAN);
  localparam logic [KEY_W-1:0] K_FWD  = KEY_W'(1 << KEY_JOG_FWD);
  localparam logic [KEY_W-1:0] K_BWD  = KEY_W'(1 << KEY_JOG_BWD);
  localparam logic [KEY_W-1:0] K_AUTO = KEY_W'(1 << KEY_AUTO);

  localparam logic [PHASE_COUNT-1:0][COIL_W-1:0] HALF_STEP_COILS =
    {4'h9, 4'h8, 4'hC, 4'h4, 4'h6, 4'h2, 4'h3, 4'h1};

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [KEY_W-1:0] key_levels_i = KEYS_RELEASED;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [COIL_W-1:0] coil_pattern_o;
  logic reverse_dir_o;
  logic in_manual_o;
  logic [DIV_W-1:0] speed_divider_o;
  logic jog_interval_we_i = 1'b0;
  logic [JOG_W-1:0] jog_interval_wdata_i = JOG_RESET;

  half_step_stepper_key_controller dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .key_levels_i         (key_levels_i),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .coil_pattern_o       (coil_pattern_o),
    .reverse_dir_o        (reverse_dir_o),
    .in_manual_o          (in_manual_o),
    .speed_divider_o      (speed_divider_o),
    .jog_interval_we_i    (jog_interval_we_i),
    .jog_interval_wdata_i (jog_interval_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Motor state as the block should hold it
  phase_t           pos_phase = PHASE_FIRST;
  logic             rev_dir = 1'b0;
  logic             manual_mode = 1'b0;
  logic [DIV_W-1:0] divider = '0;
  logic [DIV_W-1:0] tick_count = '0;
  logic [KEY_W-1:0] last_keys = KEYS_RELEASED;
  phase_t           jog_pos = PHASE_FIRST;
  logic [JOG_W-1:0] jog_wait = '0;
  logic [COIL_W-1:0] coils = '0;
  logic [JOG_W-1:0] jog_interval_now = JOG_RESET;

  logic [KEY_W-1:0] tick_queue[$];
  hssk_result_t     expected_results[$];

  int ticks_queued = 0;
  int ticks_accepted = 0;
  int results_checked = 0;
  int mismatches = 0;
  int jog_steps = 0;
  int divider_peak = 0;
  int input_stall_cycles = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  logic receiver_hold = 1'b0;

  function automatic void motor_step();
    coils = HALF_STEP_COILS[pos_phase];
    pos_phase = rev_dir ? phase_t'(pos_phase - 3'd1) : phase_t'(pos_phase + 3'd1);
  endfunction

  function automatic void jog_advance(input logic start, input logic fwd);
    logic [JOG_W-1:0] reload;
    reload = (jog_interval_now == '0) ? '0 : jog_interval_now - 8'd1;
    if (start) begin
      jog_pos = fwd ? PHASE_FIRST : PHASE_LAST;
      jog_wait = '0;
    end
    if (jog_wait == '0) begin
      pos_phase = jog_pos;
      coils = HALF_STEP_COILS[pos_phase];
      jog_pos = fwd ? phase_t'(jog_pos + 3'd1) : phase_t'(jog_pos - 3'd1);
      jog_wait = reload;
      jog_steps++;
    end else begin
      jog_wait = jog_wait - 8'd1;
    end
  endfunction

  function automatic hssk_result_t advance_motor(input logic [KEY_W-1:0] keys);
    logic [KEY_W-1:0] pressed;
    logic [KEY_W-1:0] keys_seen;
    hssk_result_t r;
    pressed = last_keys & ~keys;
    keys_seen = keys;
    if (!manual_mode) begin
      tick_count = tick_count + 8'd1;
      if (tick_count >= divider) begin
        tick_count = '0;
        motor_step();
      end
      if (pressed[KEY_DIR]) begin
        rev_dir = ~rev_dir;
        pos_phase = rev_dir ? PHASE_LAST : PHASE_FIRST;
        motor_step();
      end
      if (pressed[KEY_DEC] && divider != '0) divider = divider - 8'd1;
      if (pressed[KEY_INC] && divider != DIV_MAX) divider = divider + 8'd1;
      if (pressed[KEY_MAN]) begin
        manual_mode = 1'b1;
        // jog keys count as released on the first manual tick
        keys_seen = keys | K_FWD | K_BWD;
      end
    end else begin
      if (!keys[KEY_JOG_FWD]) begin
        jog_advance(last_keys[KEY_JOG_FWD], 1'b1);
      end else if (!keys[KEY_JOG_BWD]) begin
        jog_advance(last_keys[KEY_JOG_BWD] || !last_keys[KEY_JOG_FWD], 1'b0);
      end else if (!keys[KEY_AUTO]) begin
        manual_mode = 1'b0;
        rev_dir = 1'b0;
      end
    end
    last_keys = keys_seen;
    if (divider > divider_peak) divider_peak = divider;
    r.coil_pattern = coils;
    r.reverse_dir = rev_dir;
    r.in_manual = manual_mode;
    r.speed_divider = divider;
    return r;
  endfunction

  // Input side: one transfer per handshake, payload held while stalled
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        expected_results.push_back(advance_motor(key_levels_i));
        ticks_accepted++;
      end
      if (in_valid_i && in_stall_o) begin
        input_stall_cycles++;
      end else if (tick_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid_i <= 1'b1;
        key_levels_i <= tick_queue.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Output side
  always @(posedge clk_i) begin : result_check
    hssk_result_t got;
    hssk_result_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got.coil_pattern = coil_pattern_o;
        got.reverse_dir = reverse_dir_o;
        got.in_manual = in_manual_o;
        got.speed_divider = speed_divider_o;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result coils %h rev %b man %b div %0d", $realtime,
                     got.coil_pattern, got.reverse_dir, got.in_manual, got.speed_divider);
        end else begin
          want = expected_results.pop_front();
          results_checked++;
          if (got.coil_pattern !== want.coil_pattern || got.reverse_dir !== want.reverse_dir
              || got.in_manual !== want.in_manual
              || got.speed_divider !== want.speed_divider) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: result %0d: want %h/%b/%b/%0d, got %h/%b/%b/%0d",
                       $realtime, results_checked, want.coil_pattern, want.reverse_dir,
                       want.in_manual, want.speed_divider, got.coil_pattern,
                       got.reverse_dir, got.in_manual, got.speed_divider);
          end
        end
      end
      out_stall_i <= receiver_hold || ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Long hold-off on the result side so that the block backs up into its input
  initial begin
    while (ticks_accepted < 100) @(posedge clk_i);
    receiver_hold = 1'b1;
    repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
    receiver_hold = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d ticks still expected", cycle_count,
               expected_results.size());
      $display("half_step_stepper_key_controller_tb failed");
      $finish;
    end
  end

  // levels of the keys named in mask go low, the rest stay high
  task automatic push_down(input logic [KEY_W-1:0] mask);
    tick_queue.push_back(~mask);
    ticks_queued++;
  endtask

  task automatic drain();
    while (tick_queue.size() != 0 || in_valid_i || expected_results.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic write_jog_interval(input logic [JOG_W-1:0] value);
    @(posedge clk_i);
    jog_interval_we_i <= 1'b1;
    jog_interval_wdata_i <= value;
    jog_interval_now = value;
    @(posedge clk_i);
    jog_interval_we_i <= 1'b0;
  endtask

  task automatic queue_random_ticks(input int n);
    int target;
    int kind;
    int segs;
    int len;
    logic [KEY_W-1:0] mask;
    target = ticks_queued + n;
    while (ticks_queued < target) begin
      kind = $urandom_range(99);
      if (kind < 40) begin
        // press and release in automatic mode
        case ($urandom_range(4))
          0: mask = K_DIR;
          1: mask = K_DEC;
          2: mask = K_INC;
          3: mask = K_DEC | K_INC;
          default: mask = KEY_W'($urandom_range(7));
        endcase
        repeat ($urandom_range(1, 3)) push_down(mask);
        repeat ($urandom_range(1, 3)) push_down('0);
      end else if (kind < 70) begin
        // manual session: enter, a few jogs, back to automatic
        push_down('0);
        push_down(K_MAN);
        segs = $urandom_range(1, 5);
        repeat (segs) begin
          case ($urandom_range(3))
            0: mask = K_FWD;
            1: mask = K_BWD;
            2: mask = K_FWD | K_BWD;
            default: mask = '0;
          endcase
          len = $urandom_range(1, 12);
          repeat (len) push_down(mask);
        end
        push_down(K_AUTO);
        push_down('0);
      end else if (kind < 85) begin
        mask = $urandom_range(1) ? K_INC : K_DEC;
        repeat ($urandom_range(1, 12)) begin
          push_down(mask);
          push_down('0);
        end
      end else begin
        repeat ($urandom_range(1, 6)) push_down(KEY_W'($urandom_range(15)));
      end
    end
  endtask

  initial begin
    logic [JOG_W-1:0] mid_interval;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct = 11;
    recv_idle_pct = 48;

    // direction toggles, divider floor, all keys at once, jog starts and handovers
    push_down('0);
    push_down(K_DIR);
    push_down('0);
    push_down(K_DIR);
    push_down(K_INC);
    push_down('0);
    push_down(K_DEC);
    push_down(K_DEC);
    push_down('0);
    push_down(K_DEC);
    push_down('1);
    push_down('1);
    push_down(K_FWD);
    push_down(K_FWD | K_BWD);
    push_down(K_BWD);
    push_down(K_BWD);
    push_down('0);
    push_down(K_BWD);
    push_down(K_FWD);
    push_down(K_AUTO);
    push_down(K_AUTO | K_MAN);
    push_down('0);
    push_down(K_AUTO);
    push_down('0);
    drain();

    write_jog_interval(8'd3);
    queue_random_ticks(140);
    drain();

    // widest interval: one jog held long enough to see the reload
    write_jog_interval(DIV_MAX);
    push_down('0);
    push_down(K_AUTO);
    push_down('0);
    push_down(K_MAN);
    repeat (300) push_down(K_FWD);
    push_down(K_AUTO);
    push_down('0);
    queue_random_ticks(60);
    drain();

    send_idle_pct = 48;
    recv_idle_pct = 11;
    write_jog_interval(8'd0);
    queue_random_ticks(140);
    drain();
    write_jog_interval(8'd1);
    queue_random_ticks(100);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    mid_interval = JOG_W'($urandom_range(2, 254));
    write_jog_interval(mid_interval);
    // climb to the divider ceiling and keep pressing, then wander back down
    push_down(K_AUTO);
    push_down('0);
    repeat (256) begin
      push_down(K_INC);
      push_down('0);
    end
    queue_random_ticks(100);
    drain();
    repeat (4) @(posedge clk_i);

    $display("%0d ticks checked over jog intervals 3, 255, 0, 1 and %0d; %0d jog steps",
             results_checked, mid_interval, jog_steps);
    $display("divider reached %0d; input held back for %0d cycles; %0d mismatches",
             divider_peak, input_stall_cycles, mismatches);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("half_step_stepper_key_controller_tb passed");
    end else begin
      $display("half_step_stepper_key_controller_tb failed");
    end
    $finish;
  end

endmodule

### half_step_stepper_key_controller.f
+incdir+rtl
rtl/hssk_pkg.sv
rtl/hssk_core.sv
rtl/half_step_stepper_key_controller.sv
tb/sv/half_step_stepper_key_controller_tb.sv
